// ===== hw/rtl/ptbc_pkg.sv =====
// Shared types and constants for the PWM tone buzzer control unit.
// Holds command codes, divider and scaling constants, and the
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package ptbc_pkg;

    // Command codes carried in the mode field
    localparam logic [2:0] MODE_ON      = 3'd0;
    localparam logic [2:0] MODE_TIMED   = 3'd1;
    localparam logic [2:0] MODE_OFF     = 3'd2;
    localparam logic [2:0] MODE_VOLUME  = 3'd3;
    localparam logic [2:0] MODE_SERVICE = 3'd4;

    // Tone clock in Hz; the dividend of the period division
    localparam int unsigned DIV_BITS = 19;
    localparam logic [DIV_BITS-1:0] TONE_CLOCK = 19'd500000;
    localparam logic [4:0] DIV_LAST_BIT = 5'(DIV_BITS - 1);

    // floor(x / 7) == (x * RECIP_SEVEN) >> RECIP_SHIFT for any 15-bit x
    localparam logic [15:0] RECIP_SEVEN = 16'd37450;
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned PROD_BITS   = 31;

    localparam logic [2:0] VOLUME_RESET = 3'd7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;   // latch the incoming request, clear the divider
        logic       div_step;  // one restoring division step
        logic [4:0] bit_idx;   // dividend bit brought down in this step
        logic       mul_step;  // multiply half period by the reciprocal of seven
        logic       scale_step;// multiply by the stored volume
        logic       commit;    // apply the request to the buzzer state
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_div;       // incoming request is an on or timed command with nonzero frequency
    } status_t;

endpackage

// ===== hw/rtl/ptbc_ctrl.sv =====
// Controller for the PWM tone buzzer control unit: request handshake,
// divider sequencing and result handshake. Depends on ptbc_pkg.
`timescale 1ns / 1ps

module ptbc_ctrl
    import ptbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SCALE,
        ST_COMMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd            = '0;
        cmd.bit_idx    = cnt_reg;
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.mul_step   = (state_reg == ST_MUL);
        cmd.scale_step = (state_reg == ST_SCALE);
        cmd.commit     = (state_reg == ST_COMMIT) && out_free;
    end

    // Next state and registered outputs
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.needs_div)
                    begin
                        state_next = ST_DIV;
                        cnt_next   = DIV_LAST_BIT;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, step counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/ptbc_datapath.sv =====
// Datapath for the PWM tone buzzer control unit: request latch, restoring
// period divider, duty scaling and the buzzer state. Depends on ptbc_pkg.
`timescale 1ns / 1ps

module ptbc_datapath
    import ptbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [2:0]  mode,
    input  logic [15:0] frequency,
    input  logic [15:0] duration,
    input  logic [7:0]  new_volume,
    input  logic [31:0] now,
    output logic        enabled,
    output logic [15:0] period,
    output logic [15:0] duty,
    output logic [2:0]  volume,
    output logic        armed
);

    // Latched request
    logic [2:0]  mode_reg;
    logic [15:0] freq_reg;
    logic [2:0]  nv_reg;
    logic [31:0] now_reg;
    logic [31:0] sum_reg;

    // Divider and scaling
    logic [15:0]          rem_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [15:0]          duty_calc_reg;

    // Buzzer state
    logic        enable_reg, enable_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] duty_reg, duty_next;
    logic [2:0]  volume_reg, volume_next;
    logic [31:0] deadline_reg, deadline_next;

    logic [16:0] trial;
    logic [17:0] diff;
    logic        fits;
    logic [15:0] sat_period;
    logic        freq_zero;

    assign status.needs_div = ((mode == MODE_ON) || (mode == MODE_TIMED))
                              && (frequency != 16'd0);

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, TONE_CLOCK[cmd.bit_idx]};
    assign diff  = {1'b0, trial} - {2'b00, freq_reg};
    assign fits  = !diff[17];

    // Saturate the quotient to 16 bits
    assign sat_period = (quo_reg[DIV_BITS-1:16] != '0) ? 16'hFFFF : quo_reg[15:0];
    assign freq_zero  = (freq_reg == 16'd0);

    // Latch the request and run the divider and multipliers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            freq_reg <= frequency;
            nv_reg   <= new_volume[2:0];
            now_reg  <= now;
            sum_reg  <= now + {16'd0, duration};
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? diff[15:0] : trial[15:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
        end
        if (cmd.mul_step)
        begin
            prod_reg <= PROD_BITS'(sat_period[15:1] * RECIP_SEVEN);
        end
        if (cmd.scale_step)
        begin
            duty_calc_reg <= 16'(prod_reg[PROD_BITS-1:RECIP_SHIFT] * volume_reg);
        end
    end

    // Apply the latched request to the buzzer state
    always_comb
    begin
        enable_next   = enable_reg;
        period_next   = period_reg;
        duty_next     = duty_reg;
        volume_next   = volume_reg;
        deadline_next = deadline_reg;
        unique case (mode_reg)
            MODE_ON, MODE_TIMED:
            begin
                enable_next = 1'b0;
                if (freq_zero)
                begin
                    period_next = 16'd0;
                end
                else
                begin
                    period_next   = sat_period;
                    duty_next     = duty_calc_reg;
                    enable_next   = 1'b1;
                    deadline_next = '0;
                end
                if (mode_reg == MODE_TIMED)
                begin
                    deadline_next = sum_reg;
                end
            end
            MODE_OFF:
            begin
                enable_next   = 1'b0;
                deadline_next = '0;
            end
            MODE_VOLUME:
            begin
                volume_next = nv_reg;
            end
            MODE_SERVICE:
            begin
                if ((deadline_reg != '0) && (now_reg > deadline_reg))
                begin
                    enable_next   = 1'b0;
                    deadline_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold buzzer state; it also forms the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            period_reg   <= '0;
            duty_reg     <= '0;
            volume_reg   <= VOLUME_RESET;
            deadline_reg <= '0;
        end
        else if (cmd.commit)
        begin
            enable_reg   <= enable_next;
            period_reg   <= period_next;
            duty_reg     <= duty_next;
            volume_reg   <= volume_next;
            deadline_reg <= deadline_next;
        end
    end

    assign enabled = enable_reg;
    assign period  = period_reg;
    assign duty    = duty_reg;
    assign volume  = volume_reg;
    assign armed   = (deadline_reg != '0);

endmodule

// ===== hw/rtl/pwm_tone_buzzer_control_unit.sv =====
// PWM tone buzzer control unit: streaming command in, buzzer state out.
//
// Usage:
//   Each request on s_axis carries one command: on, timed on, off, set
//   volume or service tick. Each request yields exactly one result on
//   m_axis holding the PWM enable, period, duty, volume and armed flag
//   after the command.
//   On and timed on with a nonzero frequency run a restoring divider,
//   one quotient bit per cycle over 19 bits, then a multiply step and a
//   volume scaling step before the commit step; the next request is
//   taken only after the result is committed. All other commands go
//   from acceptance straight to the commit step.
//   One request is in work at a time; s_axis_tready is high only while
//   the unit is idle. A finished result stays in the output register
//   while the receiver stalls, and the unit takes the next request
//   meanwhile; that request's state update waits until the register is
//   free.
//   Reset clears the PWM state, disarms the deadline and sets volume 7.
// Depends on ptbc_pkg, ptbc_ctrl and ptbc_datapath.
`timescale 1ns / 1ps

module pwm_tone_buzzer_control_unit
    import ptbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // mode[2:0], frequency[18:3], duration[34:19],
                                       // new_volume[42:35], now[74:43], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // enabled[0], period[16:1], duty[32:17],
                                       // volume[35:33], armed[36], zero pad
);

    cmd_t        cmd;
    status_t     status;
    logic        enabled;
    logic [15:0] period;
    logic [15:0] duty;
    logic [2:0]  volume;
    logic        armed;

    ptbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ptbc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (s_axis_tdata[2:0]),
        .frequency  (s_axis_tdata[18:3]),
        .duration   (s_axis_tdata[34:19]),
        .new_volume (s_axis_tdata[42:35]),
        .now        (s_axis_tdata[74:43]),
        .enabled    (enabled),
        .period     (period),
        .duty       (duty),
        .volume     (volume),
        .armed      (armed)
    );

    // Pack the result fields
    assign m_axis_tdata = {3'b000, armed, volume, duty, period, enabled};

endmodule

// ===== hw/rtl/ptbc_checker.sv =====
// Port-level checks for the PWM tone buzzer control unit, bound to the
// top level. Depends on pwm_tone_buzzer_control_unit.
`timescale 1ns / 1ps

module ptbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Drop ready for the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // A new result only appears after the unit was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a request in work");

    // An enabled tone has a nonzero period and duty within half of it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[16:1] != 16'd0) && (m_axis_tdata[32:17] <= {1'b0, m_axis_tdata[16:2]}))
        else $error("enabled tone with bad period or duty");

endmodule

bind pwm_tone_buzzer_control_unit ptbc_checker u_ptbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/ptbc_checker.sv =====
// Scoreboard for the PWM tone buzzer control unit: watches both stream channels,
// predicts each result from the accepted requests and compares field by field.
// Depends on ptbc_pkg for the command codes, the tone clock and the reset volume constant.
`timescale 1ns / 1ps

module ptbc_scoreboard
    import ptbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          auto_offs
);

    localparam int unsigned VOLUME_STEPS = 7;

    // Request layout, lowest field last
    typedef struct packed {
        logic [31:0] now;
        logic [7:0]  new_volume;
        logic [15:0] duration;
        logic [15:0] frequency;
        logic [2:0]  mode;
    } buzzer_cmd_t;

    // Result layout, lowest field last
    typedef struct packed {
        logic        armed;
        logic [2:0]  volume;
        logic [15:0] duty;
        logic [15:0] period;
        logic        enabled;
    } buzzer_state_t;

    // Predicted buzzer state
    logic [2:0]  vol_level;
    logic [31:0] off_due;
    logic        pwm_on;
    logic [15:0] period_q;
    logic [15:0] duty_q;

    buzzer_state_t expected_states[$];

    // Load period and duty for a tone; a zero frequency only clears the period and stops the tone
    function automatic void start_tone(input logic [15:0] freq);
        int unsigned quotient;
        pwm_on = 1'b0;
        if (freq == 16'd0)
        begin
            period_q = 16'd0;
        end
        else
        begin
            quotient = 32'(TONE_CLOCK) / 32'(freq);
            period_q = (quotient > 32'h0000_FFFF) ? 16'hFFFF : quotient[15:0];
            if (period_q != 16'd0)
            begin
                duty_q  = 16'(((32'(period_q) >> 1) / VOLUME_STEPS) * 32'(vol_level));
                pwm_on  = 1'b1;
                off_due = 32'd0;
            end
        end
    endfunction

    // Apply one command to the predicted state and return the state after it
    function automatic buzzer_state_t apply_command(input buzzer_cmd_t cmd);
        buzzer_state_t after;
        case (cmd.mode)
            MODE_ON:
            begin
                start_tone(cmd.frequency);
            end
            MODE_TIMED:
            begin
                start_tone(cmd.frequency);
                off_due = cmd.now + 32'(cmd.duration);
            end
            MODE_OFF:
            begin
                pwm_on  = 1'b0;
                off_due = 32'd0;
            end
            MODE_VOLUME:
            begin
                vol_level = cmd.new_volume[2:0];
            end
            MODE_SERVICE:
            begin
                if (off_due != 32'd0 && cmd.now > off_due)
                begin
                    if (pwm_on)
                        auto_offs++;
                    pwm_on  = 1'b0;
                    off_due = 32'd0;
                end
            end
            default:
            begin
            end
        endcase
        after.enabled = pwm_on;
        after.period  = period_q;
        after.duty    = duty_q;
        after.volume  = vol_level;
        after.armed   = (off_due != 32'd0);
        return after;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Compare each returned result with the oldest prediction, then record new requests
    always @(posedge clk or negedge rst_n)
    begin
        buzzer_state_t got;
        buzzer_state_t want;
        if (!rst_n)
        begin
            vol_level       = VOLUME_RESET;
            off_due         = 32'd0;
            pwm_on          = 1'b0;
            period_q        = 16'd0;
            duty_q          = 16'd0;
            fail_count      = 0;
            results_checked = 0;
            auto_offs       = 0;
            expected_states.delete();
            pending         = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[36:0];
                if (expected_states.size() == 0)
                begin
                    fail_count++;
                    $error("result returned with no request outstanding: %h", m_tdata);
                end
                else
                begin
                    want = expected_states.pop_front();
                    check_field("enabled", 32'(want.enabled), 32'(got.enabled));
                    check_field("period", 32'(want.period), 32'(got.period));
                    check_field("duty", 32'(want.duty), 32'(got.duty));
                    check_field("volume", 32'(want.volume), 32'(got.volume));
                    check_field("armed", 32'(want.armed), 32'(got.armed));
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
                expected_states.push_back(apply_command(buzzer_cmd_t'(s_tdata[74:0])));
            pending = expected_states.size();
        end
    end

endmodule

// ===== tb/tb_pwm_tone_buzzer_control_unit.sv =====
// Top of the PWM tone buzzer control unit bench: clock, reset, request and
// back-pressure stimulus, and the final verdict.
// Depends on ptbc_pkg, pwm_tone_buzzer_control_unit and ptbc_scoreboard.
`timescale 1ns / 1ps

module tb_pwm_tone_buzzer_control_unit
    import ptbc_pkg::*;
;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int QUIET_TAIL      = 200;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          results_checked;
    int          auto_offs;

    int          sent_count = 0;
    int          directed_count = 0;
    int          total_target = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    logic        quiet = 1'b0;
    logic [31:0] clock_now = 32'd0;

    pwm_tone_buzzer_control_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ptbc_scoreboard u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .auto_offs       (auto_offs)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the result channel in short bursts, with calm stretches in between
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else if (rst_n && !quiet && (sent_count % 200) < 150 && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready = 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
        end
        else
        begin
            m_axis_tready = 1'b1;
        end
    end

    // Present one request, optionally after an idle burst, and hold it until taken
    task automatic send_cmd(input logic [2:0] mode, input logic [15:0] freq,
                            input logic [15:0] dur, input logic [7:0] vol,
                            input logic [31:0] now);
        int gap;
        @(negedge clk);
        if (!quiet && (sent_count % 200) < 150 && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = {5'b0, now, vol, dur, freq, mode};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
        quiet = (total_target > 0) && (sent_count >= total_target - QUIET_TAIL);
    endtask

    // Favor zero, saturating and near-limit frequencies
    function automatic logic [15:0] pick_freq();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 7));
            2:       return 16'($urandom_range(8, 40));
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Timed tone, sometimes after a volume change, then service ticks mostly around its deadline
    task automatic play_timed_tone();
        logic [15:0] dur;
        logic [31:0] due;
        int          ticks;
        if ($urandom_range(0, 3) == 0)
            send_cmd(MODE_VOLUME, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
        dur = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        case ($urandom_range(0, 15))
            0:       clock_now = 32'd0 - 32'(dur);
            1:       clock_now = $urandom;
            2:       clock_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));
            default: clock_now = clock_now + 32'($urandom_range(1, 1000));
        endcase
        send_cmd(MODE_TIMED, pick_freq(), dur, 8'($urandom), clock_now);
        due = clock_now + 32'(dur);
        ticks = $urandom_range(1, 4);
        repeat (ticks)
        begin
            if ($urandom_range(0, 4) == 0)
                clock_now = $urandom;
            else
                clock_now = due + 32'($urandom_range(0, 4)) - 32'd2;
            send_cmd(MODE_SERVICE, 16'($urandom), 16'($urandom), 8'($urandom), clock_now);
        end
        case ($urandom_range(0, 5))
            0:       send_cmd(MODE_OFF, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
            1:       send_cmd(MODE_ON, pick_freq(), 16'($urandom), 8'($urandom), $urandom);
            default: ;
        endcase
    endtask

    initial
    begin
        // Hold reset, then release away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every command and the corner cases
        send_cmd(MODE_SERVICE, 16'd0, 16'd0, 8'd0, 32'd5);
        send_cmd(MODE_ON, 16'd0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(MODE_ON, 16'd1, 16'd0, 8'd0, 32'd0);
        send_cmd(MODE_ON, 16'd7, 16'd0, 8'd0, 32'd0);
        send_cmd(MODE_ON, 16'd8, 16'd0, 8'd0, 32'd0);
        send_cmd(MODE_ON, 16'hFFFF, 16'd0, 8'd0, 32'd0);
        send_cmd(MODE_VOLUME, 16'd0, 16'd0, 8'hF8, 32'd0);
        send_cmd(MODE_ON, 16'd1000, 16'd0, 8'd0, 32'd0);
        send_cmd(MODE_VOLUME, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(MODE_TIMED, 16'd440, 16'd100, 8'd0, 32'd1000);
        send_cmd(MODE_SERVICE, 16'd0, 16'd0, 8'd0, 32'd1100);
        send_cmd(MODE_SERVICE, 16'd0, 16'd0, 8'd0, 32'd1101);
        send_cmd(MODE_TIMED, 16'd0, 16'd50, 8'd0, 32'd2000);
        send_cmd(MODE_SERVICE, 16'd0, 16'd0, 8'd0, 32'hFFFF_FFFF);
        send_cmd(MODE_TIMED, 16'd2000, 16'h0010, 8'd0, 32'hFFFF_FFF0);
        send_cmd(MODE_TIMED, 16'hFFFF, 16'hFFFF, 8'd0, 32'hFFFF_0000);
        send_cmd(MODE_SERVICE, 16'd0, 16'd0, 8'd0, 32'hFFFF_FFFF);
        send_cmd(MODE_OFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(MODE_TIMED, 16'd300, 16'd10, 8'd0, 32'd100);
        send_cmd(MODE_ON, 16'd0, 16'd0, 8'd0, 32'd200);
        send_cmd(MODE_SERVICE, 16'd0, 16'd0, 8'd0, 32'd111);
        send_cmd(MODE_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(MODE_SPARE_FIRST + 3'd1, 16'd0, 16'd0, 8'd0, 32'd0);
        send_cmd(MODE_SPARE_FIRST + 3'd2, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
        directed_count = sent_count;
        total_target = directed_count + RANDOM_REQUESTS;

        // Random: mostly timed tone sequences, the rest loose commands of any code
        while (sent_count < total_target)
        begin
            if ($urandom_range(0, 9) < 6)
                play_timed_tone();
            else
                send_cmd(3'($urandom_range(0, 7)), pick_freq(), 16'($urandom),
                         8'($urandom), $urandom);
        end

        // Drain every outstanding result, then let the unit settle
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests (%0d directed), checked %0d results",
                 sent_count, directed_count, results_checked);
        $display("Deadline expiries that silenced a running tone: %0d", auto_offs);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
